### hw/rtl/running_average_background_subtractor_top_defines.svh
// Assertion helpers for the top-level RTL.
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACTOR_TOP_DEFINES_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACTOR_TOP_DEFINES_SVH

// Generic clocked assertion, masked while reset is held.
`define RABS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Shorthand for the house clock and reset names.
`define RABS_ASSERT_CLK(lbl, prop, msg) \
    `RABS_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

### hw/rtl/rabs_pkg.sv
package rabs_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    // register reset values
    localparam logic [CFG_W-1:0] LEARN_RATE_RST   = 17'd3277;
    localparam logic [CFG_W-1:0] FRAME_PIXELS_RST = 17'd65536;
    localparam logic             THR_ENABLE_RST   = 1'b0;
    localparam logic [PIX_W-1:0] THR_LEVEL_RST    = 8'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE   = 2'd0,
        CFG_FRAME_PIXELS = 2'd1,
        CFG_THR_ENABLE   = 2'd2,
        CFG_THR_LEVEL    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             enable;
        logic [PIX_W-1:0] level;
    } t_thr_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] foreground_value;
        logic [PIX_W-1:0] background_value;
        logic             frame_end;
    } t_res_out;

endpackage

### hw/rtl/rabs_stream_if.sv
interface rabs_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/running_average_background_subtractor_top.sv
// Running-average background subtractor for 8-bit grey video.
// i_pix carries one pixel per transaction in raster order; o_res returns one
// transaction per pixel: foreground (|pixel - background| or a 0/255 mask),
// the updated background byte and a frame_end flag on the last pixel.
// Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data, to be written by
// the user only while the block is idle; the block itself does not enforce it.
// Registers: learn rate, frame length, mask enable and level.
// Throughput: one pixel per clock while o_res is not stalled, set by the
// single read-modify-write pass over the background RAM (one read and one
// write port per cycle). The RAM is read into the blend stage at the accept
// edge; blend and write-back then go into the output register on o_res.
// Back-to-back pixels on the same RAM entry (very short frames) are served by
// forwarding the last written byte.
// Reset clears the pixel position, the valid flags, the configuration registers
// and the "first frame" flag; the RAM itself is not cleared: the first frame
// after reset loads it and gives foreground 0.
// If o_res stalls, the result holds in the output register, one more pixel
// sits in the blend stage, and i_pix.ready drops until the output is taken.
`include "running_average_background_subtractor_top_defines.svh"

module running_average_background_subtractor_top
    import rabs_pkg::*;
#(
    parameter int MAX_PIXELS     = 65536,
    parameter int RATE_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    rabs_stream_if.sink          i_pix,
    rabs_stream_if.source        o_res
);

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    // frame-length compare must hold both the register and MAX_PIXELS
    localparam int LEN_W  = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
    localparam int RATE_W = RATE_FRAC_BITS + 1;
    localparam int CMP_W  = (RATE_W > CFG_W) ? RATE_W : CFG_W;

    // configuration registers
    logic [CFG_W-1:0]  r_learn_rate;
    logic [CFG_W-1:0]  r_frame_pixels;
    t_thr_cfg          r_thr;

    // frame tracking
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] n_pos;
    logic              r_loaded;
    logic              n_loaded;

    // blend stage (pixel whose RAM read is in flight)
    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_loaded;
    logic              r_s1_last;
    logic              r_s1_fwd;

    // last write-back, for forwarding
    logic [ADDR_W-1:0] r_wr_addr;
    logic [PIX_W-1:0]  r_wr_data;

    // output register
    logic              r_out_valid;
    t_res_out          r_out;

    logic              in_fire;
    logic              s1_fire;
    logic [LEN_W-1:0]  frame_ext;
    logic [LEN_W-1:0]  max_len;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  pos_inc;
    logic              last;
    logic [CMP_W-1:0]  rate_ext;
    logic [CMP_W-1:0]  rate_one;
    logic [RATE_W-1:0] rate_sat;
    logic [PIX_W-1:0]  rd_data;
    logic [PIX_W-1:0]  bg_old;
    logic [PIX_W-1:0]  fg_new;
    logic [PIX_W-1:0]  bg_new;

    // ---------------------------------------------------------------- handshake
    assign s1_fire     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || s1_fire;
    assign in_fire     = i_pix.valid && i_pix.ready;

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate   <= LEARN_RATE_RST;
            r_frame_pixels <= FRAME_PIXELS_RST;
            r_thr.enable   <= THR_ENABLE_RST;
            r_thr.level    <= THR_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LEARN_RATE:   r_learn_rate   <= i_cfg_data;
                CFG_FRAME_PIXELS: r_frame_pixels <= i_cfg_data;
                CFG_THR_ENABLE:   r_thr.enable   <= i_cfg_data[0];
                CFG_THR_LEVEL:    r_thr.level    <= i_cfg_data[PIX_W-1:0];
            endcase
        end
    end

    // Learn rate above one saturates to one.
    always_comb begin
        rate_ext = CMP_W'(r_learn_rate);
        rate_one = CMP_W'(1) << RATE_FRAC_BITS;
        rate_sat = RATE_W'((rate_ext > rate_one) ? rate_one : rate_ext);
    end

    // ---------------------------------------------------------------- position
    // Zero frame length acts as one, lengths past the RAM as the RAM depth.
    // A position already at or past a lowered length ends the frame at once.
    always_comb begin
        frame_ext = LEN_W'(r_frame_pixels);
        max_len   = LEN_W'(MAX_PIXELS);
        if (frame_ext == '0) begin
            eff_len = LEN_W'(1);
        end else if (frame_ext > max_len) begin
            eff_len = max_len;
        end else begin
            eff_len = frame_ext;
        end
        pos_inc  = LEN_W'(r_pos) + LEN_W'(1);
        last     = (pos_inc >= eff_len);
        n_pos    = last ? '0 : pos_inc[ADDR_W-1:0];
        n_loaded = r_loaded || last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_loaded <= 1'b0;
        end else if (in_fire) begin
            r_pos    <= n_pos;
            r_loaded <= n_loaded;
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // The RAM read is read-first: if the previous pixel writes the same entry
    // in the accept cycle, take its byte from the write-back register instead.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pix    <= i_pix.data.pixel_value;
            r_s1_addr   <= r_pos;
            r_s1_loaded <= r_loaded;
            r_s1_last   <= last;
            r_s1_fwd    <= s1_fire && (r_s1_addr == r_pos);
        end
    end

    rabs_bg_ram #(
        .DEPTH  (MAX_PIXELS),
        .ADDR_W (ADDR_W),
        .DATA_W (PIX_W)
    ) u_bg_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (bg_new)
    );

    assign bg_old = r_s1_fwd ? r_wr_data : rd_data;

    rabs_blend #(
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_blend (
        .i_pixel  (r_s1_pix),
        .i_bg_old (bg_old),
        .i_loaded (r_s1_loaded),
        .i_rate   (rate_sat),
        .i_thr    (r_thr),
        .o_fg     (fg_new),
        .o_bg     (bg_new)
    );

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_wr_addr <= r_s1_addr;
            r_wr_data <= bg_new;
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out.foreground_value <= fg_new;
            r_out.background_value <= bg_new;
            r_out.frame_end        <= r_s1_last;
        end
    end

    // ---------------------------------------------------------------- checks
    `RABS_ASSERT_CLK(a_pos_wraps, in_fire && last |=> r_pos == '0, "position not cleared at frame end")
    `RABS_ASSERT_CLK(a_fwd_addr, r_s1_valid && r_s1_fwd |-> r_wr_addr == r_s1_addr, "forwarding from wrong entry")
    `RABS_ASSERT_CLK(a_first_frame, s1_fire && !r_s1_loaded |=> r_out.foreground_value == '0 && r_out.background_value == $past(r_s1_pix), "first frame not loaded directly")
    `RABS_ASSERT_CLK(a_no_overrun, r_s1_valid && !s1_fire |-> !in_fire, "pixel accepted over stalled stage")

endmodule

### hw/rtl/rabs_bg_ram.sv
module rabs_bg_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // read-first; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/rabs_blend.sv
module rabs_blend
    import rabs_pkg::*;
#(
    parameter int  RATE_FRAC_BITS = 16,
    localparam int RATE_W         = RATE_FRAC_BITS + 1
) (
    input  logic [PIX_W-1:0]  i_pixel,
    input  logic [PIX_W-1:0]  i_bg_old,
    input  logic              i_loaded,
    input  logic [RATE_W-1:0] i_rate,
    input  t_thr_cfg          i_thr,
    output logic [PIX_W-1:0]  o_fg,
    output logic [PIX_W-1:0]  o_bg
);

    // b*one + a*(p - b) + one/2, signed, with headroom
    localparam int PROD_W = RATE_W + PIX_W + 2;

    logic signed [PIX_W:0]    diff;
    logic [PIX_W-1:0]         abs_diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] base;
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] blend;

    always_comb begin
        diff     = $signed({1'b0, i_pixel}) - $signed({1'b0, i_bg_old});
        abs_diff = (i_pixel > i_bg_old) ? (i_pixel - i_bg_old) : (i_bg_old - i_pixel);
        prod     = PROD_W'($signed({1'b0, i_rate})) * PROD_W'(diff);
        base     = $signed(PROD_W'({i_bg_old, {RATE_FRAC_BITS{1'b0}}}));
        half     = $signed(PROD_W'(1) << (RATE_FRAC_BITS - 1));
        blend    = base + prod + half;
    end

    always_comb begin
        if (!i_loaded) begin
            o_fg = '0;
            o_bg = i_pixel;
        end else begin
            if (i_thr.enable) begin
                o_fg = (abs_diff > i_thr.level) ? PIX_MAX : '0;
            end else begin
                o_fg = abs_diff;
            end
            // blend always lies in 0 .. 255.5 * one
            o_bg = blend[RATE_FRAC_BITS +: PIX_W];
        end
    end

endmodule
